[sv/hrlp_pkg.sv]
package hrlp_pkg;

  // Fixed character and length constants of a record line
  localparam logic [7:0] START_CHAR   = 8'h3A;
  localparam int unsigned MIN_LINE    = 11;
  localparam int unsigned WINDOW_HIGH = 13;

  // Record type codes
  localparam logic [7:0] REC_DATA     = 8'h00;
  localparam logic [7:0] REC_EOF      = 8'h01;
  localparam logic [7:0] REC_EXT_ADDR = 8'h04;

  typedef enum logic [3:0] {
    ST_DATA       = 4'd0,
    ST_EXT_ADDR   = 4'd1,
    ST_EOF        = 4'd2,
    ST_BAD_FIRST  = 4'd3,
    ST_NON_HEX    = 4'd4,
    ST_BAD_COUNT  = 4'd5,
    ST_BAD_SUM    = 4'd6,
    ST_BAD_TYPE   = 4'd7,
    ST_BAD_RECORD = 4'd8
  } status_e;

  // Per-line summary handed from the parser to the replay unit
  typedef struct packed {
    status_e     status;
    logic [7:0]  byte_count;
    logic [15:0] load_address;
    logic [7:0]  record_type;
    logic [7:0]  word_count;
    logic        bank;
  } line_sum_t;

  // Word store write port
  typedef struct packed {
    logic        en;
    logic        bank;
    logic [6:0]  idx;
    logic [15:0] data;
  } word_wr_t;

endpackage

[sv/hex_record_line_parser.sv]
// Hex record line parser: takes one ASCII character of a record line per
// cycle, flagged last character ends the line. It checks the leading colon,
// hex digits, the line length against the declared byte count and the 8-bit
// checksum, and packs data bytes two to a 16-bit word into a two-bank word
// memory. After the last character it emits one item per packed word (or a
// single item when there are none), each carrying the line status and header.
// Characters are accepted every cycle; the last character of a line is held
// off only while the previous line is still being replayed. Replay reads each
// word through the registered read of the word memory into the output
// register, one read at a time. No clearing pass is needed after reset.
module hex_record_line_parser
  import hrlp_pkg::*;
#(
  parameter int unsigned MAX_LINE_CHARS = 45,
  parameter int unsigned MAX_WORDS      = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  char_in_i,
  input  logic        line_end_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [3:0]  status_o,
  output logic [7:0]  byte_count_o,
  output logic [15:0] load_address_o,
  output logic [7:0]  record_type_o,
  output logic [3:0]  word_count_o,
  output logic [2:0]  word_index_o,
  output logic [15:0] data_word_o,
  output logic        word_valid_o,
  output logic        run_last_o
);

  word_wr_t  wr;
  line_sum_t line_sum;
  logic      sum_load;
  logic      busy;
  logic      accept;

  // Hold the last character while the previous line is still replaying
  assign in_stall_o = line_end_i && busy;
  assign accept     = in_valid_i && !in_stall_o;

  hrlp_parser #(
    .MAX_LINE_CHARS (MAX_LINE_CHARS),
    .MAX_WORDS      (MAX_WORDS)
  ) u_parser (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .char_in_i  (char_in_i),
    .line_end_i (line_end_i),
    .wr_o       (wr),
    .sum_load_o (sum_load),
    .sum_o      (line_sum)
  );

  hrlp_replay #(
    .MAX_WORDS (MAX_WORDS)
  ) u_replay (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .wr_i           (wr),
    .sum_load_i     (sum_load),
    .sum_i          (line_sum),
    .busy_o         (busy),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .status_o       (status_o),
    .byte_count_o   (byte_count_o),
    .load_address_o (load_address_o),
    .record_type_o  (record_type_o),
    .word_count_o   (word_count_o),
    .word_index_o   (word_index_o),
    .data_word_o    (data_word_o),
    .word_valid_o   (word_valid_o),
    .run_last_o     (run_last_o)
  );

endmodule

[sv/hrlp_parser.sv]
module hrlp_parser
  import hrlp_pkg::*;
#(
  parameter int unsigned MAX_LINE_CHARS = 45,
  parameter int unsigned MAX_WORDS      = 8
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      accept_i,
  input  logic [7:0] char_in_i,
  input  logic      line_end_i,
  output word_wr_t  wr_o,
  output logic      sum_load_o,
  output line_sum_t sum_o
);

  localparam int unsigned POS_W = $clog2(MAX_LINE_CHARS + 2);
  localparam int unsigned CMP_W = (((POS_W + 1) > 10) ? (POS_W + 1) : 10) + 1;
  localparam int unsigned CNT_W = $clog2(MAX_WORDS + 1);

  logic [POS_W-1:0] pos_q, pos_d;
  logic             fb_q, fb_d;
  logic             nh_q, nh_d;
  logic [3:0]       nib_q, nib_d;
  logic [7:0]       hi_q, hi_d;
  logic [7:0]       count_q, count_d;
  logic [15:0]      addr_q, addr_d;
  logic [7:0]       type_q, type_d;
  logic [7:0]       sum_q, sum_d;
  logic [CNT_W-1:0] wp_q, wp_d;
  logic             bank_q, bank_d;

  logic [3:0]       nib_c;
  logic             hex_ok_c;
  logic [7:0]       byte_c;
  logic [CMP_W-1:0] k_c, d_c, w_c, len_c, lo_c, hi_lim_c;
  logic             show_hdr_c, show_words_c;
  status_e          status_c;

  function automatic logic [4:0] hex_decode(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b1, 4'(c - 8'h37)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b1, 4'(c - 8'h57)};
    end
    return r;
  endfunction

  assign {hex_ok_c, nib_c} = hex_decode(char_in_i);
  assign byte_c = {nib_q, nib_c};
  assign k_c    = CMP_W'((pos_q - POS_W'(2)) >> 1);
  assign d_c    = k_c - CMP_W'(4);
  assign w_c    = d_c >> 1;

  // Decode one character, then close the line on its last character
  always_comb begin
    pos_d   = pos_q;
    fb_d    = fb_q;
    nh_d    = nh_q;
    nib_d   = nib_q;
    hi_d    = hi_q;
    count_d = count_q;
    addr_d  = addr_q;
    type_d  = type_q;
    sum_d   = sum_q;
    wp_d    = wp_q;
    bank_d  = bank_q;
    wr_o    = '0;

    if (accept_i) begin
      if (pos_q == '0) begin
        fb_d = (char_in_i != START_CHAR);
      end else begin
        if (!hex_ok_c) nh_d = 1'b1;
        if (pos_q <= POS_W'(MAX_LINE_CHARS)) begin
          if (pos_q[0]) begin
            nib_d = nib_c;
          end else begin
            priority if (k_c == CMP_W'(0)) begin
              count_d = byte_c;
            end else if (k_c == CMP_W'(1)) begin
              addr_d[15:8] = byte_c;
            end else if (k_c == CMP_W'(2)) begin
              addr_d[7:0] = byte_c;
            end else if (k_c == CMP_W'(3)) begin
              type_d = byte_c;
            end else begin
              // Pack data bytes that fit the store, drop the rest
              if (d_c < CMP_W'(count_q) && w_c < CMP_W'(MAX_WORDS)) begin
                if (!d_c[0]) begin
                  hi_d = byte_c;
                end else begin
                  wr_o.en   = 1'b1;
                  wr_o.bank = bank_q;
                  wr_o.idx  = 7'(w_c);
                  wr_o.data = {hi_q, byte_c};
                  wp_d      = CNT_W'(w_c + CMP_W'(1));
                end
              end
            end
            if (k_c <= CMP_W'(count_d) + CMP_W'(4)) sum_d = sum_q + byte_c;
          end
        end
      end
      if (pos_q != POS_W'(MAX_LINE_CHARS + 1)) pos_d = pos_q + POS_W'(1);
    end

    // Judge the line from the updated state
    len_c        = CMP_W'(pos_q) + CMP_W'(1);
    lo_c         = CMP_W'(MIN_LINE) + CMP_W'({count_d, 1'b0});
    hi_lim_c     = CMP_W'(WINDOW_HIGH) + CMP_W'({count_d, 1'b0});
    show_hdr_c   = 1'b1;
    show_words_c = 1'b1;
    priority if (fb_d) begin
      status_c = ST_BAD_FIRST; show_hdr_c = 1'b0; show_words_c = 1'b0;
    end else if (nh_d) begin
      status_c = ST_NON_HEX; show_hdr_c = 1'b0; show_words_c = 1'b0;
    end else if (len_c < CMP_W'(MIN_LINE) || len_c > CMP_W'(MAX_LINE_CHARS)) begin
      status_c = ST_BAD_COUNT; show_hdr_c = 1'b0; show_words_c = 1'b0;
    end else if (len_c < lo_c || len_c > hi_lim_c) begin
      status_c = ST_BAD_COUNT; show_words_c = 1'b0;
    end else if (sum_d != 8'd0) begin
      status_c = ST_BAD_SUM;
    end else if (type_d == REC_DATA && count_d != 8'd0) begin
      status_c = ST_DATA;
    end else if (type_d == REC_EXT_ADDR && count_d == 8'd2) begin
      status_c = ST_EXT_ADDR;
    end else if (type_d == REC_EOF && count_d == 8'd0) begin
      status_c = ST_EOF;
    end else if (type_d != REC_DATA && type_d != REC_EOF && type_d != REC_EXT_ADDR) begin
      status_c = ST_BAD_TYPE;
    end else begin
      status_c = ST_BAD_RECORD;
    end

    sum_o.status       = status_c;
    sum_o.byte_count   = show_hdr_c ? count_d : 8'd0;
    sum_o.load_address = show_hdr_c ? addr_d : 16'd0;
    sum_o.record_type  = show_hdr_c ? type_d : 8'd0;
    sum_o.word_count   = show_words_c ? 8'(wp_d) : 8'd0;
    sum_o.bank         = bank_q;
    sum_load_o         = accept_i && line_end_i;

    // Clear line state and flip the word bank after the last character
    if (accept_i && line_end_i) begin
      pos_d   = '0;
      fb_d    = 1'b0;
      nh_d    = 1'b0;
      nib_d   = 4'd0;
      hi_d    = 8'd0;
      count_d = 8'd0;
      addr_d  = 16'd0;
      type_d  = 8'd0;
      sum_d   = 8'd0;
      wp_d    = '0;
      bank_d  = !bank_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      fb_q    <= 1'b0;
      nh_q    <= 1'b0;
      nib_q   <= 4'd0;
      hi_q    <= 8'd0;
      count_q <= 8'd0;
      addr_q  <= 16'd0;
      type_q  <= 8'd0;
      sum_q   <= 8'd0;
      wp_q    <= '0;
      bank_q  <= 1'b0;
    end else begin
      pos_q   <= pos_d;
      fb_q    <= fb_d;
      nh_q    <= nh_d;
      nib_q   <= nib_d;
      hi_q    <= hi_d;
      count_q <= count_d;
      addr_q  <= addr_d;
      type_q  <= type_d;
      sum_q   <= sum_d;
      wp_q    <= wp_d;
      bank_q  <= bank_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_o.en |-> accept_i && pos_q[0] == 1'b0)
    else $error("word write outside a data byte");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    sum_load_o |=> pos_q == '0 && wp_q == '0)
    else $error("line state not cleared after line end");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    sum_load_o |=> bank_q != $past(bank_q))
    else $error("word bank did not flip at line end");

endmodule

[sv/hrlp_replay.sv]
module hrlp_replay
  import hrlp_pkg::*;
#(
  parameter int unsigned MAX_WORDS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  word_wr_t    wr_i,
  input  logic        sum_load_i,
  input  line_sum_t   sum_i,
  output logic        busy_o,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [3:0]  status_o,
  output logic [7:0]  byte_count_o,
  output logic [15:0] load_address_o,
  output logic [7:0]  record_type_o,
  output logic [3:0]  word_count_o,
  output logic [2:0]  word_index_o,
  output logic [15:0] data_word_o,
  output logic        word_valid_o,
  output logic        run_last_o
);

  localparam int unsigned IDX_W = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_WORDS + 1);
  localparam int unsigned DEPTH = 2 ** (IDX_W + 1);

  logic [15:0]      mem [DEPTH];
  logic [15:0]      rdata_q;

  line_sum_t        sum_q;
  logic             busy_q;
  logic [CNT_W-1:0] idx_q;
  logic             rd_pend_q;
  logic [CNT_W-1:0] rd_idx_q;

  logic             out_vld_q;
  status_e          out_status_q;
  logic [7:0]       out_count_q;
  logic [15:0]      out_addr_q;
  logic [7:0]       out_type_q;
  logic [3:0]       out_wcount_q;
  logic [2:0]       out_widx_q;
  logic [15:0]      out_data_q;
  logic             out_wvalid_q;
  logic             out_last_q;

  logic [CNT_W-1:0] nw_c, nres_c;
  logic             take_c, issue_c, last_c;

  assign nw_c    = CNT_W'(sum_q.word_count);
  assign nres_c  = (nw_c == '0) ? CNT_W'(1) : nw_c;
  assign take_c  = out_vld_q && !out_stall_i;
  // Issue a read only when the output register is free by the time data returns
  assign issue_c = busy_q && (idx_q < nres_c) && !rd_pend_q && (!out_vld_q || take_c);
  assign last_c  = (rd_idx_q + CNT_W'(1)) == nres_c;

  // Word store: parser writes one bank while the other is replayed
  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[{wr_i.bank, wr_i.idx[IDX_W-1:0]}] <= wr_i.data;
    end
    if (issue_c) begin
      rdata_q <= mem[{sum_q.bank, idx_q[IDX_W-1:0]}];
    end
  end

  // Hold the line summary and step through its words
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q    <= 1'b0;
      idx_q     <= '0;
      rd_pend_q <= 1'b0;
      rd_idx_q  <= '0;
    end else begin
      if (sum_load_i) begin
        busy_q <= 1'b1;
        idx_q  <= '0;
      end else if (issue_c) begin
        idx_q <= idx_q + CNT_W'(1);
      end
      if (issue_c) begin
        rd_pend_q <= 1'b1;
        rd_idx_q  <= idx_q;
      end else if (rd_pend_q) begin
        rd_pend_q <= 1'b0;
        if (last_c) busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (sum_load_i) sum_q <= sum_i;
  end

  // Output register: load on read return, drop when taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (rd_pend_q) begin
      out_vld_q <= 1'b1;
    end else if (take_c) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_pend_q) begin
      out_status_q <= sum_q.status;
      out_count_q  <= sum_q.byte_count;
      out_addr_q   <= sum_q.load_address;
      out_type_q   <= sum_q.record_type;
      out_wcount_q <= 4'(nw_c);
      out_widx_q   <= 3'(rd_idx_q);
      out_data_q   <= (nw_c != '0) ? rdata_q : 16'd0;
      out_wvalid_q <= (nw_c != '0);
      out_last_q   <= last_c;
    end
  end

  assign busy_o         = busy_q;
  assign out_valid_o    = out_vld_q;
  assign status_o       = out_status_q;
  assign byte_count_o   = out_count_q;
  assign load_address_o = out_addr_q;
  assign record_type_o  = out_type_q;
  assign word_count_o   = out_wcount_q;
  assign word_index_o   = out_widx_q;
  assign data_word_o    = out_data_q;
  assign word_valid_o   = out_wvalid_q;
  assign run_last_o     = out_last_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_pend_q |-> !out_vld_q || !out_stall_i || $past(!out_vld_q))
    else $error("read returned into an occupied output register");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    sum_load_i |-> !busy_q)
    else $error("line summary loaded while replay busy");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    issue_c |-> idx_q < nres_c)
    else $error("word read past the end of the line");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_pend_q && last_c |=> !busy_q)
    else $error("replay stayed busy after its last word");

endmodule

[test/hex_record_line_parser_test.sv]
module hex_record_line_parser_test;
  import hrlp_pkg::*;

  localparam int unsigned MAX_LINE_CHARS = 45;
  localparam int unsigned MAX_WORDS      = 8;
  localparam int          NO_TYPED       = -1;
  localparam int          RANDOM_CHARS   = 40;
  localparam int          RANDOM_RESULTS = 6;
  localparam int          LONG_HOLD      = 400;
  localparam int          DRAIN_CYCLES   = 50;
  localparam int          CYCLE_LIMIT    = 300000;

  // ASCII digit ranges
  localparam logic [7:0] CHAR_0  = 8'h30;
  localparam logic [7:0] CHAR_9  = 8'h39;
  localparam logic [7:0] CHAR_UA = 8'h41;
  localparam logic [7:0] CHAR_UF = 8'h46;
  localparam logic [7:0] CHAR_LA = 8'h61;
  localparam logic [7:0] CHAR_LF = 8'h66;
  // In directed text, '^' stands for a NUL byte and '~' for 0xFF
  localparam logic [7:0] MARK_NUL = 8'h5E;
  localparam logic [7:0] MARK_FF  = 8'h7E;

  typedef logic [7:0] char_q_t [$];

  typedef struct {
    status_e     status;
    logic [7:0]  byte_count;
    logic [15:0] load_address;
    logic [7:0]  record_type;
    logic [3:0]  word_count;
    logic [2:0]  word_index;
    logic [15:0] data_word;
    logic        word_valid;
    logic        run_last;
  } record_out_t;

  typedef struct {
    string text;
    int    typed;
  } directed_row_t;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_stall_o;
  logic [7:0]  char_in_i   = 8'h00;
  logic        line_end_i  = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [3:0]  status_o;
  logic [7:0]  byte_count_o;
  logic [15:0] load_address_o;
  logic [7:0]  record_type_o;
  logic [3:0]  word_count_o;
  logic [2:0]  word_index_o;
  logic [15:0] data_word_o;
  logic        word_valid_o;
  logic        run_last_o;

  // Line state of the predictor
  int unsigned line_pos;
  bit          bad_lead;
  bit          saw_nonhex;
  logic [3:0]  hi_nib;
  logic [7:0]  rec_count;
  logic [15:0] rec_addr;
  logic [7:0]  rec_type;
  logic [7:0]  csum;
  logic [15:0] word_buf [MAX_WORDS];
  int unsigned n_words;

  record_out_t pending_records [$];
  int          typed_status_q [$];
  int          status_hits [9];
  int          error_count       = 0;
  int          chars_sent        = 0;
  int          lines_sent        = 0;
  int          predicted_results = 0;
  int          results_checked   = 0;
  int          cycle_count       = 0;
  bit          hold_request      = 1'b0;
  bit          hold_done         = 1'b0;

  directed_row_t directed_rows [18] = '{
    '{":00000001FF", ST_EOF},
    '{":0200000400FFFB", ST_EXT_ADDR},
    '{":04FFFF00deadbeefC6", ST_DATA},
    '{":11000000000102030405060708090A0B0C0D0E0F1067", NO_TYPED},
    '{"~00000001FF", ST_BAD_FIRST},
    '{":00000001^F", ST_NON_HEX},
    '{":/@G`g:", ST_NON_HEX},
    '{":", ST_BAD_COUNT},
    '{{":00000001FF", "0000000000", "0000000000", "0000000000", "0000", "Z"}, ST_NON_HEX},
    '{":0300000000FD", ST_BAD_COUNT},
    '{":00000001FF7", ST_EOF},
    '{":00000001FFA5", ST_EOF},
    '{":00000001FE", ST_BAD_SUM},
    '{":00000002FE", ST_BAD_TYPE},
    '{":0000000000", ST_BAD_RECORD},
    '{":0100000400FB", ST_BAD_RECORD},
    '{":03123400AABBCC86", NO_TYPED},
    '{":01000000FF00", NO_TYPED}
  };

  hex_record_line_parser i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .char_in_i      (char_in_i),
    .line_end_i     (line_end_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .status_o       (status_o),
    .byte_count_o   (byte_count_o),
    .load_address_o (load_address_o),
    .record_type_o  (record_type_o),
    .word_count_o   (word_count_o),
    .word_index_o   (word_index_o),
    .data_word_o    (data_word_o),
    .word_valid_o   (word_valid_o),
    .run_last_o     (run_last_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic bit decode_hex(input logic [7:0] c, output logic [3:0] v);
    v = 4'h0;
    if (c >= CHAR_0 && c <= CHAR_9) v = 4'(c - CHAR_0);
    else if (c >= CHAR_UA && c <= CHAR_UF) v = 4'(c - CHAR_UA + 8'd10);
    else if (c >= CHAR_LA && c <= CHAR_LF) v = 4'(c - CHAR_LA + 8'd10);
    else return 1'b0;
    return 1'b1;
  endfunction

  // Encode a nibble as a hex digit, letters in either case
  function automatic logic [7:0] hex_char(input logic [3:0] v);
    if (v < 4'd10) return CHAR_0 + 8'(v);
    return ($urandom_range(0, 1) ? CHAR_LA : CHAR_UA) + 8'(v) - 8'd10;
  endfunction

  // Advance the line state by one character; at line end queue the results
  task automatic parse_char(input logic [7:0] c, input logic last);
    int unsigned len, n, k, d, w, nw, nres;
    logic [3:0]  nib;
    logic [7:0]  b;
    bit          show_hdr, show_words;
    status_e     st;
    record_out_t r;
    int          typed;
    len = line_pos + 1;
    if (line_pos == 0) begin
      bad_lead = (c != START_CHAR);
    end else begin
      if (!decode_hex(c, nib)) saw_nonhex = 1'b1;
      if (line_pos <= MAX_LINE_CHARS) begin
        if (line_pos % 2 == 1) begin
          hi_nib = nib;
        end else begin
          k = (line_pos - 2) / 2;
          b = {hi_nib, nib};
          if (k == 0) rec_count = b;
          else if (k == 1) rec_addr[15:8] = b;
          else if (k == 2) rec_addr[7:0] = b;
          else if (k == 3) rec_type = b;
          else begin
            d = k - 4;
            w = d / 2;
            // pack data bytes high byte first, drop words past the store
            if (d < rec_count && w < MAX_WORDS) begin
              if (d % 2 == 0) begin
                word_buf[w] = {b, 8'h00};
              end else begin
                word_buf[w] = word_buf[w] | {8'h00, b};
                n_words = w + 1;
              end
            end
          end
          // skip the extra characters allowed after the checksum
          if (k <= 4 + rec_count) csum = csum + b;
        end
      end
    end
    if (line_pos < MAX_LINE_CHARS + 1) line_pos++;
    if (!last) return;

    n = rec_count;
    show_hdr = 1'b1;
    show_words = 1'b1;
    if (bad_lead) begin
      st = ST_BAD_FIRST; show_hdr = 1'b0; show_words = 1'b0;
    end else if (saw_nonhex) begin
      st = ST_NON_HEX; show_hdr = 1'b0; show_words = 1'b0;
    end else if (len < MIN_LINE || len > MAX_LINE_CHARS) begin
      st = ST_BAD_COUNT; show_hdr = 1'b0; show_words = 1'b0;
    end else if (len < MIN_LINE + 2 * n || len > WINDOW_HIGH + 2 * n) begin
      st = ST_BAD_COUNT; show_words = 1'b0;
    end else if (csum != 8'h00) st = ST_BAD_SUM;
    else if (rec_type == REC_DATA && n > 0) st = ST_DATA;
    else if (rec_type == REC_EXT_ADDR && n == 2) st = ST_EXT_ADDR;
    else if (rec_type == REC_EOF && n == 0) st = ST_EOF;
    else if (rec_type != REC_DATA && rec_type != REC_EOF && rec_type != REC_EXT_ADDR)
      st = ST_BAD_TYPE;
    else st = ST_BAD_RECORD;

    // a status typed into the directed table takes precedence
    typed = (typed_status_q.size() != 0) ? typed_status_q.pop_front() : NO_TYPED;
    if (typed != NO_TYPED) st = status_e'(typed);
    status_hits[st]++;

    nw = show_words ? n_words : 0;
    nres = (nw != 0) ? nw : 1;
    for (int unsigned i = 0; i < nres; i++) begin
      r.status       = st;
      r.byte_count   = show_hdr ? rec_count : 8'h00;
      r.load_address = show_hdr ? rec_addr : 16'h0000;
      r.record_type  = show_hdr ? rec_type : 8'h00;
      r.word_count   = 4'(nw);
      r.word_index   = 3'(i);
      r.data_word    = (nw != 0) ? word_buf[i] : 16'h0000;
      r.word_valid   = (nw != 0);
      r.run_last     = (i + 1 == nres);
      pending_records.push_back(r);
      predicted_results++;
    end

    line_pos   = 0;
    bad_lead   = 1'b0;
    saw_nonhex = 1'b0;
    hi_nib     = 4'h0;
    rec_count  = 8'h00;
    rec_addr   = 16'h0000;
    rec_type   = 8'h00;
    csum       = 8'h00;
    n_words    = 0;
  endtask

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s expected 0x%0h, got 0x%0h", $time, name, want, got);
      error_count++;
    end
  endtask

  // Predict on every accepted character
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o) parse_char(char_in_i, line_end_i);
  end

  // Check every accepted result against the oldest prediction
  always @(posedge clk_i) begin : result_check
    record_out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_records.size() == 0) begin
        $display("%0t: result with none expected, status 0x%0h word 0x%0h",
                 $time, status_o, data_word_o);
        error_count++;
      end else begin
        want = pending_records.pop_front();
        compare_field("status", want.status, status_o);
        compare_field("byte_count", want.byte_count, byte_count_o);
        compare_field("load_address", want.load_address, load_address_o);
        compare_field("record_type", want.record_type, record_type_o);
        compare_field("word_count", want.word_count, word_count_o);
        compare_field("word_index", want.word_index, word_index_o);
        compare_field("data_word", want.data_word, data_word_o);
        compare_field("word_valid", want.word_valid, word_valid_o);
        compare_field("run_last", want.run_last, run_last_o);
        results_checked++;
      end
    end
  end

  // Bound the run
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: run stopped after %0d cycles", $time, cycle_count);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Output stall: runs of no stall, short stalls, a few long ones and one long hold
  initial begin : receiver
    int pick;
    int len;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      pick = $urandom_range(0, 99);
      if (hold_request && !hold_done) begin
        out_stall_i <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk_i);
        hold_done = 1'b1;
      end else if (pick < 50) begin
        out_stall_i <= 1'b0;
        len = $urandom_range(1, 24);
        repeat (len) @(posedge clk_i);
      end else if (pick < 90) begin
        out_stall_i <= 1'b1;
        len = $urandom_range(1, 3);
        repeat (len) @(posedge clk_i);
      end else begin
        out_stall_i <= 1'b1;
        len = $urandom_range(8, 40);
        repeat (len) @(posedge clk_i);
      end
    end
  end

  // Offer one character, hold it until taken, then maybe idle
  task automatic send_char(input logic [7:0] c, input logic last, input bit steady);
    int pick;
    int gap;
    in_valid_i <= 1'b1;
    char_in_i  <= c;
    line_end_i <= last;
    do @(posedge clk_i); while (in_stall_o);
    chars_sent++;
    pick = $urandom_range(0, 19);
    if (steady || pick < 11) gap = 0;
    else if (pick < 18) gap = $urandom_range(1, 3);
    else gap = $urandom_range(8, 30);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic send_line(input char_q_t chars, input int typed);
    bit steady;
    steady = ($urandom_range(0, 3) == 0);
    typed_status_q.push_back(typed);
    foreach (chars[i]) send_char(chars[i], i == chars.size() - 1, steady);
    lines_sent++;
  endtask

  // Build a random line: mostly well-formed records, some damaged, some noise
  task automatic make_random_line(output char_q_t chars);
    int          kind;
    int          n;
    int          nbytes;
    logic [7:0]  rtype;
    logic [7:0]  csum_byte;
    logic [15:0] addr;
    char_q_t     bytes;
    chars = {};
    bytes = {};
    kind = $urandom_range(0, 99);
    if (kind < 25) begin
      nbytes = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 50) : $urandom_range(1, 16);
      chars.push_back($urandom_range(0, 1) ? START_CHAR : 8'($urandom_range(0, 255)));
      repeat (nbytes - 1)
        chars.push_back(($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                                     : hex_char(4'($urandom)));
    end else begin
      addr = 16'($urandom);
      unique case ($urandom_range(0, 7))
        0, 1, 2, 3: begin
          rtype = REC_DATA;
          n = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 17) : $urandom_range(1, 6);
        end
        4: begin
          rtype = REC_EXT_ADDR;
          n = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 3) : 2;
        end
        5: begin
          rtype = REC_EOF;
          n = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 2) : 0;
        end
        6: begin
          rtype = 8'($urandom);
          n = $urandom_range(0, 6);
        end
        default: begin
          rtype = REC_DATA;
          n = $urandom_range(18, 255);
        end
      endcase
      bytes.push_back(8'(n));
      bytes.push_back(addr[15:8]);
      bytes.push_back(addr[7:0]);
      bytes.push_back(rtype);
      nbytes = (n > 20) ? 20 : n;
      repeat (nbytes) bytes.push_back(8'($urandom));
      csum_byte = 8'h00;
      foreach (bytes[i]) csum_byte = csum_byte - bytes[i];
      if ($urandom_range(0, 9) == 0) csum_byte = csum_byte + 8'($urandom_range(1, 255));
      bytes.push_back(csum_byte);
      chars.push_back(START_CHAR);
      foreach (bytes[i]) begin
        chars.push_back(hex_char(bytes[i][7:4]));
        chars.push_back(hex_char(bytes[i][3:0]));
      end
      // damage a few lines: trailing digits, truncation, stray byte, bad lead
      if ($urandom_range(0, 5) == 0) begin
        unique case ($urandom_range(0, 3))
          0: repeat ($urandom_range(1, 2)) chars.push_back(hex_char(4'($urandom)));
          1: repeat ($urandom_range(1, 2)) void'(chars.pop_back());
          2: chars[$urandom_range(1, chars.size() - 1)] = 8'($urandom);
          default: chars[0] = 8'($urandom);
        endcase
      end
    end
  endtask

  initial begin : stimulus
    char_q_t line;
    int      first_char;
    int      first_result;
    string   hits;
    foreach (status_hits[i]) status_hits[i] = 0;
    foreach (word_buf[i]) word_buf[i] = 16'h0000;
    line_pos = 0; bad_lead = 1'b0; saw_nonhex = 1'b0; hi_nib = 4'h0;
    rec_count = 8'h00; rec_addr = 16'h0000; rec_type = 8'h00; csum = 8'h00; n_words = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Walk the directed table, with one long output hold early on
    hold_request = 1'b1;
    foreach (directed_rows[r]) begin
      line = {};
      for (int i = 0; i < directed_rows[r].text.len(); i++) begin
        if (directed_rows[r].text[i] == MARK_NUL) line.push_back(8'h00);
        else if (directed_rows[r].text[i] == MARK_FF) line.push_back(8'hFF);
        else line.push_back(directed_rows[r].text[i]);
      end
      send_line(line, directed_rows[r].typed);
    end

    // Random lines
    first_char = chars_sent;
    first_result = predicted_results;
    while (chars_sent - first_char < RANDOM_CHARS ||
           predicted_results - first_result < RANDOM_RESULTS) begin
      make_random_line(line);
      send_line(line, NO_TYPED);
    end
    in_valid_i <= 1'b0;

    // Drain
    @(posedge clk_i);
    while (pending_records.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    hits = "";
    foreach (status_hits[i]) hits = {hits, $sformatf(" %0d", status_hits[i])};
    $display("Sent %0d characters in %0d lines, checked %0d results",
             chars_sent, lines_sent, results_checked);
    $display("Lines per status 0..8:%s", hits);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
